/* hw/rtl/acfp_pkg.sv */
`default_nettype none

package acfp_pkg;

    // Number of bytes of one field that take part in the conversion.
    localparam int FIELD_CHARS = 14;
    localparam int FLEN_W      = $clog2(FIELD_CHARS + 1);

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int ADDR_W         = 3;
    localparam int REG_IDX_W      = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_LEN = '0;
    localparam logic [7:0] MAX_LEN_RESET = 8'd150;

    // Byte codes of the frame syntax.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Magnitude bound and positive limit of a converted field.
    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Comma positions that close the velocity and steering fields.
    localparam logic [1:0] COMMA_VEL = 2'd1;
    localparam logic [1:0] COMMA_STR = 2'd2;
    localparam logic [1:0] COMMA_MAX = 2'd3;
    localparam logic [1:0] FRAC_MAX  = 2'd3;

    typedef enum logic [1:0] {
        FR_HUNT,
        FR_START,
        FR_BODY
    } t_frame;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [31:0]       accum;
        logic              negative;
        t_phase            phase;
        logic [1:0]        frac;
        logic [FLEN_W-1:0] len;
    } t_field;

    localparam t_field FIELD_CLEAR = '{
        accum:    32'd0,
        negative: 1'b0,
        phase:    PH_BLANK,
        frac:     2'd0,
        len:      '0
    };

    typedef struct packed {
        logic [31:0] velocity;
        logic [31:0] steering;
        logic        vel_upd;
        logic        str_upd;
    } t_result;

    // Weight in thousandths of a fraction digit at the given position.
    function automatic logic [6:0] frac_weight(input logic [1:0] pos);
        logic [6:0] w;
        case (pos)
            2'd0:    w = 7'd100;
            2'd1:    w = 7'd10;
            default: w = 7'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ascii_command_frame_parser.sv */
`default_nettype none
// The '*' closing a frame pushes a result beat into the output register or skid entry.
// Throughput: one received byte per cycle while o_rx_stall is low; the per-byte update
// is one pass of the frame and field logic between the state registers.
// A two-entry result queue keeps bytes flowing while one result waits downstream.
// Reset is synchronous and active low; it empties the queue and clears all held state.

module ascii_command_frame_parser
    import acfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_rx_valid,
    output logic                   o_rx_stall,
    input  wire logic [7:0]        i_rx_byte,

    output logic                   o_res_valid,
    input  wire logic              i_res_stall,
    output logic signed [31:0]     o_velocity_milli,
    output logic signed [31:0]     o_steering_milli,
    output logic                   o_velocity_updated,
    output logic                   o_steering_updated,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_frame      r_state, n_state;
    logic [7:0]  r_fb, n_fb;
    logic [1:0]  r_commas, n_commas;
    t_field      r_fld, n_fld;
    t_field      fld_fed;
    logic [31:0] fld_value;
    logic [31:0] r_pend_vel, n_pend_vel;
    logic [31:0] r_pend_str, n_pend_str;
    logic [1:0]  r_pend_flags, n_pend_flags;
    logic [31:0] r_held_vel, n_held_vel;
    logic [31:0] r_held_str, n_held_str;
    logic [7:0]  r_max_len;
    logic        accept;
    logic        push;
    logic        pop;
    logic [7:0]  fb_inc;
    t_result     res_new;
    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_MAX_FRAME_LEN) ? {24'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[ADDR_W-1:2] == REG_MAX_FRAME_LEN) begin
            r_max_len <= pwdata[7:0];
        end
    end

    // Field conversion for the byte on the input.
    acfp_field u_field (
        .i_byte  (i_rx_byte),
        .i_cur   (r_fld),
        .o_next  (fld_fed),
        .o_value (fld_value)
    );

    assign o_rx_stall = r_skid_valid;
    assign accept     = i_rx_valid && !o_rx_stall;
    assign fb_inc     = (r_fb != 8'd255) ? r_fb + 8'd1 : r_fb;

    // Frame tracking and field bookkeeping for one accepted byte.
    always_comb begin
        n_state      = r_state;
        n_fb         = r_fb;
        n_commas     = r_commas;
        n_fld        = r_fld;
        n_pend_vel   = r_pend_vel;
        n_pend_str   = r_pend_str;
        n_pend_flags = r_pend_flags;
        n_held_vel   = r_held_vel;
        n_held_str   = r_held_str;
        push         = 1'b0;
        if (accept) begin
            if (i_rx_byte == CH_DOLLAR) begin
                n_state      = (8'd1 >= r_max_len) ? FR_HUNT : FR_START;
                n_fb         = 8'd1;
                n_commas     = 2'd0;
                n_fld        = FIELD_CLEAR;
                n_pend_vel   = 32'd0;
                n_pend_str   = 32'd0;
                n_pend_flags = 2'd0;
            end else if (r_state != FR_HUNT) begin
                if (r_state == FR_START &&
                    !(i_rx_byte inside {CH_COMMA, CH_TAB, CH_LF, CH_STAR})) begin
                    n_state = FR_HUNT;
                end else if (i_rx_byte == CH_STAR) begin
                    if (r_pend_flags[0]) begin
                        n_held_vel = r_pend_vel;
                    end
                    if (r_pend_flags[1]) begin
                        n_held_str = r_pend_str;
                    end
                    push    = 1'b1;
                    n_state = FR_HUNT;
                end else begin
                    n_fb    = fb_inc;
                    n_state = (fb_inc >= r_max_len) ? FR_HUNT : FR_BODY;
                    if (i_rx_byte == CH_COMMA) begin
                        if (r_commas == COMMA_VEL) begin
                            n_pend_vel      = fld_value;
                            n_pend_flags[0] = 1'b1;
                        end else if (r_commas == COMMA_STR) begin
                            n_pend_str      = fld_value;
                            n_pend_flags[1] = 1'b1;
                        end
                        if (r_commas != COMMA_MAX) begin
                            n_commas = r_commas + 2'd1;
                        end
                        n_fld = FIELD_CLEAR;
                    end else begin
                        n_fld = fld_fed;
                    end
                end
            end
        end
    end

    assign res_new = '{
        velocity: n_held_vel,
        steering: n_held_str,
        vel_upd:  r_pend_flags[0],
        str_upd:  r_pend_flags[1]
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= FR_HUNT;
            r_fb         <= 8'd0;
            r_commas     <= 2'd0;
            r_fld        <= FIELD_CLEAR;
            r_pend_vel   <= 32'd0;
            r_pend_str   <= 32'd0;
            r_pend_flags <= 2'd0;
            r_held_vel   <= 32'd0;
            r_held_str   <= 32'd0;
        end else begin
            r_state      <= n_state;
            r_fb         <= n_fb;
            r_commas     <= n_commas;
            r_fld        <= n_fld;
            r_pend_vel   <= n_pend_vel;
            r_pend_str   <= n_pend_str;
            r_pend_flags <= n_pend_flags;
            r_held_vel   <= n_held_vel;
            r_held_str   <= n_held_str;
        end
    end

    // Result queue: an output register backed by one skid entry.
    assign pop = r_out_valid && !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= push;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= push;
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (pop || !r_out_valid) begin
            r_out <= res_new;
        end
        if (!pop && r_out_valid && push) begin
            r_skid <= res_new;
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_velocity_milli   = r_out.velocity;
    assign o_steering_milli   = r_out.steering;
    assign o_velocity_updated = r_out.vel_upd;
    assign o_steering_updated = r_out.str_upd;

    // The skid entry is only ever filled behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without an output beat");

    // A terminator inside a frame body always yields a result beat.
    a_star_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state == FR_BODY && i_rx_byte == CH_STAR) |=> r_out_valid)
        else $error("terminator produced no result beat");

    // While hunting, only a start byte leaves the hunt.
    a_hunt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FR_HUNT && !(accept && i_rx_byte == CH_DOLLAR)) |=> r_state == FR_HUNT)
        else $error("left hunt without a start byte");

    // The field magnitude never passes the saturation bound.
    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fld.accum <= SAT_MAG)
        else $error("field magnitude beyond saturation bound");

endmodule

`default_nettype wire

/* hw/rtl/acfp_field.sv */
`default_nettype none

module acfp_field
    import acfp_pkg::*;
(
    input  wire logic [7:0]  i_byte,
    input  wire t_field      i_cur,
    output t_field           o_next,
    output logic [31:0]      o_value
);

    logic        digit;
    logic        blank;
    logic [3:0]  d;
    logic [35:0] int_sum;
    logic [32:0] frac_sum;
    logic [31:0] int_sat;
    logic [31:0] frac_sat;

    assign digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign blank = (i_byte == CH_SPACE) || (i_byte inside {[CH_TAB:CH_CR]});
    assign d     = i_byte[3:0];

    // Integer digit: accum * 10 + d * 1000, capped at the magnitude bound.
    assign int_sum = ({4'b0, i_cur.accum} << 3) + ({4'b0, i_cur.accum} << 1)
                   + 36'(14'(d) * 14'd1000);
    assign int_sat = (int_sum > 36'(SAT_MAG)) ? SAT_MAG : int_sum[31:0];

    // Fraction digit: add the digit at the weight of its position.
    assign frac_sum = {1'b0, i_cur.accum} + 33'(11'(d) * 11'(frac_weight(i_cur.frac)));
    assign frac_sat = (frac_sum > 33'(SAT_MAG)) ? SAT_MAG : frac_sum[31:0];

    // Next field state after one more text byte.
    always_comb begin
        o_next = i_cur;
        if (i_cur.len < FLEN_W'(FIELD_CHARS)) begin
            o_next.len = i_cur.len + 1'b1;
            if (i_cur.phase == PH_BLANK && blank) begin
                o_next.phase = PH_BLANK;
            end else if (i_cur.phase == PH_BLANK &&
                         (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                o_next.negative = (i_byte == CH_MINUS);
                o_next.phase    = PH_SIGN;
            end else begin
                case (i_cur.phase)
                    PH_BLANK, PH_SIGN, PH_INT: begin
                        if (digit) begin
                            o_next.accum = int_sat;
                            o_next.phase = PH_INT;
                        end else if (i_byte == CH_DOT) begin
                            o_next.phase = PH_FRAC;
                        end else begin
                            o_next.phase = PH_DONE;
                        end
                    end
                    PH_FRAC: begin
                        if (digit) begin
                            if (i_cur.frac < FRAC_MAX) begin
                                o_next.accum = frac_sat;
                                o_next.frac  = i_cur.frac + 2'd1;
                            end
                        end else begin
                            o_next.phase = PH_DONE;
                        end
                    end
                    default: begin
                        o_next.phase = i_cur.phase;
                    end
                endcase
            end
        end
    end

    // Signed value of the field as it stands, positive side clamped.
    always_comb begin
        if (i_cur.negative) begin
            o_value = 32'd0 - i_cur.accum;
        end else begin
            o_value = (i_cur.accum > POS_MAX) ? POS_MAX : i_cur.accum;
        end
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOW_MAX    = 10;

    // One byte waiting to be sent; a marked byte is held back until every
    // outstanding command update has been seen.
    typedef struct {
        logic [7:0] b;
        bit         drain;
    } rx_beat_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_rx_valid = 1'b0;
    logic              o_rx_stall;
    logic [7:0]        i_rx_byte  = '0;
    logic              o_res_valid;
    logic              i_res_stall = 1'b0;
    logic signed [31:0] o_velocity_milli;
    logic signed [31:0] o_steering_milli;
    logic              o_velocity_updated;
    logic              o_steering_updated;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    ascii_command_frame_parser dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_valid         (i_rx_valid),
        .o_rx_stall         (o_rx_stall),
        .i_rx_byte          (i_rx_byte),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_velocity_milli   (o_velocity_milli),
        .o_steering_milli   (o_steering_milli),
        .o_velocity_updated (o_velocity_updated),
        .o_steering_updated (o_steering_updated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus store and expected command updates.
    rx_beat_t rx_q[$];
    t_result  updates_due[$];
    bit       hold_next    = 1'b0;
    int       bytes_queued = 0;
    int       fail_count   = 0;
    int       cycle_count  = 0;

    logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};

    // Parser mirror: frame tracking, the field being converted, and the
    // pending and held command values.
    logic [7:0]  frame_limit  = MAX_LEN_RESET;
    bit          in_frame     = 1'b0;
    bit          after_dollar = 1'b0;
    logic [7:0]  frame_len    = '0;
    logic [1:0]  commas       = '0;
    logic [31:0] fld_mag      = '0;
    bit          fld_neg      = 1'b0;
    t_phase      fld_phase    = PH_BLANK;
    logic [1:0]  fld_frac     = '0;
    int          fld_seen     = 0;
    logic [31:0] vel_pending  = '0;
    logic [31:0] str_pending  = '0;
    bit          vel_seen     = 1'b0;
    bit          str_seen     = 1'b0;
    logic [31:0] vel_held     = '0;
    logic [31:0] str_held     = '0;

    function automatic void clear_field();
        fld_mag   = '0;
        fld_neg   = 1'b0;
        fld_phase = PH_BLANK;
        fld_frac  = '0;
        fld_seen  = 0;
    endfunction

    // Signed thousandths of the field collected so far.
    function automatic logic [31:0] field_milli();
        if (fld_neg)
            return 32'd0 - fld_mag;
        return (fld_mag > POS_MAX) ? POS_MAX : fld_mag;
    endfunction

    // One byte of decimal text: blanks, sign, integer digits, point, fraction.
    function automatic void convert_char(input logic [7:0] c);
        logic [63:0] sum;
        logic [31:0] weight;
        bit          is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (fld_seen >= FIELD_CHARS)
            return;
        fld_seen++;
        if (fld_phase == PH_BLANK && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
            return;
        if (fld_phase == PH_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
            fld_neg   = (c == CH_MINUS);
            fld_phase = PH_SIGN;
            return;
        end
        if (fld_phase == PH_BLANK || fld_phase == PH_SIGN || fld_phase == PH_INT) begin
            if (is_digit) begin
                sum       = 64'(fld_mag) * 64'd10 + 64'(c[3:0]) * 64'd1000;
                fld_mag   = (sum > 64'(SAT_MAG)) ? SAT_MAG : sum[31:0];
                fld_phase = PH_INT;
            end else if (c == CH_DOT) begin
                fld_phase = PH_FRAC;
            end else begin
                fld_phase = PH_DONE;
            end
        end else if (fld_phase == PH_FRAC) begin
            if (is_digit) begin
                if (fld_frac != FRAC_MAX) begin
                    weight   = (fld_frac == 2'd0) ? 32'd100 : (fld_frac == 2'd1) ? 32'd10 : 32'd1;
                    sum      = 64'(fld_mag) + 64'(c[3:0]) * 64'(weight);
                    fld_mag  = (sum > 64'(SAT_MAG)) ? SAT_MAG : sum[31:0];
                    fld_frac = fld_frac + 2'd1;
                end
            end else begin
                fld_phase = PH_DONE;
            end
        end
    endfunction

    // Advances the mirror by one accepted byte and queues the update a '*' causes.
    function automatic void track_byte(input logic [7:0] c);
        t_result upd;
        if (c == CH_DOLLAR) begin
            in_frame     = 1'b1;
            after_dollar = 1'b1;
            frame_len    = 8'd1;
            commas       = '0;
            clear_field();
            vel_pending  = '0;
            str_pending  = '0;
            vel_seen     = 1'b0;
            str_seen     = 1'b0;
            if (frame_len >= frame_limit) begin
                in_frame     = 1'b0;
                after_dollar = 1'b0;
            end
            return;
        end
        if (!in_frame)
            return;
        if (after_dollar) begin
            after_dollar = 1'b0;
            if (!(c == CH_COMMA || c == CH_TAB || c == CH_LF || c == CH_STAR)) begin
                in_frame = 1'b0;
                return;
            end
        end
        if (c == CH_STAR) begin
            if (vel_seen)
                vel_held = vel_pending;
            if (str_seen)
                str_held = str_pending;
            upd.velocity = vel_held;
            upd.steering = str_held;
            upd.vel_upd  = vel_seen;
            upd.str_upd  = str_seen;
            updates_due.push_back(upd);
            in_frame = 1'b0;
            return;
        end
        if (frame_len != 8'd255)
            frame_len = frame_len + 8'd1;
        if (c == CH_COMMA) begin
            if (commas == COMMA_VEL) begin
                vel_pending = field_milli();
                vel_seen    = 1'b1;
            end else if (commas == COMMA_STR) begin
                str_pending = field_milli();
                str_seen    = 1'b1;
            end
            if (commas != COMMA_MAX)
                commas = commas + 2'd1;
            clear_field();
        end else begin
            convert_char(c);
        end
        if (frame_len >= frame_limit)
            in_frame = 1'b0;
    endfunction

    // Stimulus building.
    function automatic void push_byte(input logic [7:0] b);
        rx_q.push_back('{b, hold_next});
        hold_next = 1'b0;
        bytes_queued++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    // A byte that carries no meaning to the frame syntax.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA ||
                   b == CH_TAB || b == CH_LF);
        return b;
    endfunction

    function automatic void push_number();
        int sel;
        int n;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            repeat ($urandom_range(10, 16)) push_byte(CH_SPACE);
        else if (sel < 6)
            repeat ($urandom_range(1, 3)) push_byte(blanks[$urandom_range(0, 5)]);
        sel = $urandom_range(0, 3);
        if (sel == 0)
            push_byte(CH_PLUS);
        else if (sel == 1)
            push_byte(CH_MINUS);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 13) : $urandom_range(0, 4);
        repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) < 3) begin
            push_byte(CH_DOT);
            repeat ($urandom_range(0, 5)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 6) == 0) begin
            push_byte(plain_byte());
            repeat ($urandom_range(0, 2)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // A mostly well-formed frame with random field text.
    function automatic void push_frame();
        int sel;
        push_byte(CH_DOLLAR);
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            push_byte(plain_byte());
        end else if (sel == 1) begin
            push_byte(CH_TAB);
        end else if (sel == 2) begin
            push_byte(CH_LF);
        end else if (sel == 3) begin
            push_byte(CH_STAR);
            return;
        end else begin
            push_byte(CH_COMMA);
        end
        repeat ($urandom_range(0, 2)) push_byte(8'h61 + 8'($urandom_range(0, 25)));
        repeat ($urandom_range(0, 4)) begin
            push_byte(CH_COMMA);
            push_number();
        end
        if ($urandom_range(0, 3) != 0)
            push_byte(CH_COMMA);
        if ($urandom_range(0, 19) != 0)
            push_byte(CH_STAR);
    endfunction

    function automatic void fill_random(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            push_frame();
        end
    endfunction

    // Waits until every byte went in and every update came out, then lets
    // the parser settle.
    task automatic wait_idle();
        while (rx_q.size() != 0 || i_rx_valid || updates_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_frame_limit(input logic [7:0] limit);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_FRAME_LEN, 2'b00};
        pwdata  <= {24'd0, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_limit = limit;
    endtask

    // Byte sender: random gaps between beats, with stretches of back-to-back bytes.
    int rx_gap   = 0;
    bit rx_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= '0;
            rx_gap     <= 0;
        end else begin
            if (i_rx_valid && !o_rx_stall)
                track_byte(i_rx_byte);
            if (!i_rx_valid || !o_rx_stall) begin
                if (rx_gap > 0) begin
                    rx_gap     <= rx_gap - 1;
                    i_rx_valid <= 1'b0;
                end else if (rx_q.size() != 0 &&
                             !(rx_q[0].drain && updates_due.size() != 0)) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= rx_q[0].b;
                    rx_q.pop_front();
                    if ($urandom_range(0, 63) == 0)
                        rx_burst = !rx_burst;
                    rx_gap <= rx_burst ? 0 : $urandom_range(0, 10);
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // Update receiver: random stalls, compared beat by beat against the mirror.
    int stall_left = 0;
    bit res_burst  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_res_valid && !i_res_stall) begin
                if (updates_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("unexpected update beat: vel %0d str %0d upd %b%b",
                                 o_velocity_milli, o_steering_milli,
                                 o_velocity_updated, o_steering_updated);
                end else begin
                    if (o_velocity_milli !== updates_due[0].velocity ||
                        o_steering_milli !== updates_due[0].steering ||
                        o_velocity_updated !== updates_due[0].vel_upd ||
                        o_steering_updated !== updates_due[0].str_upd) begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("update mismatch: expected vel %0d str %0d upd %b%b, %s",
                                     $signed(updates_due[0].velocity),
                                     $signed(updates_due[0].steering),
                                     updates_due[0].vel_upd, updates_due[0].str_upd,
                                     $sformatf("got vel %0d str %0d upd %b%b",
                                               o_velocity_milli, o_steering_milli,
                                               o_velocity_updated, o_steering_updated));
                    end
                    updates_due.pop_front();
                end
                stall_left = res_burst ? 0 : $urandom_range(0, 10);
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!res_burst && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if ($urandom_range(0, 299) == 0)
                res_burst = !res_burst;
            i_res_stall <= (stall_left > 0);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ascii_command_frame_parser");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset length.
        set_frame_limit(MAX_LEN_RESET);
        push_text("$,x,1.5,-2.25,*");
        push_text("$,x,+007.1239,  -0.0019,*");
        push_text("$,x,99999999,-99999999,*");
        push_text("$,x,2147483.647,-2147483.648,*");
        push_text("$,x,2147483.648,-2147483.649,*");
        push_text("$*");
        push_text("$,x,5*");
        push_text("$,x,,,*");
        push_text("$A,1,2,3,**");
        push_text("$\t,x,3,4,5,6,*");
        push_text("$\n,x,12a3,-.5x,*");
        push_text("$,x,             45,3,*");
        push_text("$,x,9,$,x,7,8,*");
        push_text("$,x,");
        push_byte(8'hFF);
        push_text(",+-1,*");
        push_byte(8'h00);
        // Leave a frame open across a lowered length limit.
        push_text("$,x,11,22,");
        wait_idle();
        set_frame_limit(8'd3);
        push_text("*$*$,*$,1*$\t*");
        fill_random(20);
        wait_idle();

        // Widest limit; the sender drains all updates once midway.
        set_frame_limit(8'd255);
        fill_random(80);
        hold_next = 1'b1;
        fill_random(80);
        wait_idle();

        // Tightest limits, including those that drop every frame at the start byte.
        set_frame_limit(8'd2);
        push_text("$*$,*$\n*");
        fill_random(30);
        wait_idle();
        set_frame_limit(8'd1);
        fill_random(20);
        wait_idle();
        set_frame_limit(8'd0);
        fill_random(20);
        wait_idle();

        set_frame_limit(8'd40);
        fill_random(70);
        wait_idle();
        set_frame_limit(8'd12);
        fill_random(70);
        wait_idle();
        set_frame_limit(MAX_LEN_RESET);
        fill_random(70);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && updates_due.size() == 0) begin
            $display("PASS ascii_command_frame_parser");
        end else begin
            $display("FAIL ascii_command_frame_parser");
        end
        $finish;
    end

endmodule

`default_nettype wire
